FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWLC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PWLC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/pwlc_pkg.sv
// Shared types and constants of the piecewise-linear curve evaluator.
package pwlc_pkg;

  localparam int VAL_W  = 32;
  localparam int PCNT_W = 7;
  localparam int DIVD_W = 64;
  localparam int DIVS_W = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_BUILD = 2'd2,
    CMD_EVAL  = 2'd3
  } cmd_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/pwlc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module pwlc_div
  import pwlc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic [DIVD_W-1:0] quotient_o,
  output div_stat_t         stat_o
);

  localparam int CNT_W = $clog2(DIVD_W);

  logic [DIVD_W-1:0] quo_q;
  logic [DIVS_W-1:0] rem_q;
  logic [DIVS_W-1:0] dvs_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W:0]   rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, quo_q[DIVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVD_W-2:0], ge};
      rem_q <= ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: rtl/piecewise_linear_curve_eval.sv
// Piecewise-linear curve evaluator: sample table, sort/merge build, evaluate.
//
// One input channel (in_valid_i / in_stall_o) carries a command with its
// operands; one output channel (out_valid_o / out_stall_i) returns exactly one
// result per command. A transaction is taken while the sequencer is idle.
// Steps per command, from the accepting edge to the result being offered:
//   clear, add, evaluate without a curve : straight to the response state
//   build    : in-place insertion sort of the samples (n samples, d distinct
//              x), then a merge pass over the sorted table; each group mean
//              goes through the serial divider
//   evaluate : linear scan of the merged table up to k >= 1, the breakpoint
//              that ends the scan, then a multiply and a divider pass
// Rate is set by the sample memory's single read port and the serial divider
// during a build and by the serial divider on an evaluate with a curve; one command is in work at a time.
// A finished result sits in the output register; the next command is
// accepted while it waits, and the sequencer holds its next result until the
// register is free. A stalled output keeps its payload.
// Reset clears the counts and the curve-valid flag; the memories are not
// cleared, entries are only used below the fill count.
module piecewise_linear_curve_eval
  import pwlc_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               command_i,
  input  logic signed [VAL_W-1:0]  sample_x_i,
  input  logic signed [VAL_W-1:0]  sample_y_i,
  input  logic signed [VAL_W-1:0]  query_x_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [VAL_W-1:0]  curve_value_o,
  output logic [1:0]               status_o,
  output logic                     saturated_o,
  output logic [PCNT_W-1:0]        point_count_o
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = VAL_W + CW;
  localparam int EW = 2 * VAL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SORT_RD, S_SORT_KEY, S_SORT_CMP, S_SORT_PUT,
    S_MRG_RD, S_MRG_CHK, S_MRG_DIV,
    S_EV_RD, S_EV_CHK, S_EV_MUL, S_EV_DST, S_EV_DIV, S_RESP
  } state_e;

  state_e state_q;

  logic [EW-1:0] raw_mem [MAX_POINTS];
  logic [EW-1:0] mrg_mem [MAX_POINTS];
  logic [EW-1:0] raw_rd_q;
  logic [EW-1:0] mrg_rd_q;

  logic          raw_we;
  logic [AW-1:0] raw_waddr;
  logic [EW-1:0] raw_wdata;
  logic [AW-1:0] raw_raddr;
  logic          mrg_we;
  logic [EW-1:0] mrg_wdata;

  logic [CW-1:0] stored_q, distinct_q;
  logic          ready_q;
  logic [CW-1:0] i_q, j_q, mi_q, m_q, cnt_q, k_q;
  logic signed [VAL_W-1:0] key_x_q, key_y_q, cur_x_q, qx_q, prev_x_q, prev_y_q, base_q;
  logic signed [SW-1:0]    sum_q;
  logic [VAL_W-1:0]        mdy_q, mdq_q, span_q;
  logic                    neg_q;
  logic [EW-1:0]           prod_q;

  logic signed [VAL_W-1:0] res_value_q;
  logic [1:0]              res_status_q;
  logic                    res_sat_q;
  logic                    out_valid_q;

  logic accept, full, shift;
  logic signed [VAL_W-1:0] rx, ry, ex, ey, bx, by, mean;
  logic [CW-1:0]           j_m1, j_m2, i_m1, i_p1, last_k;
  logic                    last, hit, base_cur;
  logic signed [VAL_W:0]   dy, dq, span;
  logic [VAL_W:0]          mdy, mdq;
  logic [SW-1:0]           sum_mag;

  logic                    div_start;
  logic [DIVD_W-1:0]       div_a, div_q;
  logic [DIVS_W-1:0]       div_b;
  div_stat_t               div_stat;

  logic [VAL_W+1:0]        qc;
  logic signed [VAL_W+3:0] r;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;
  assign full       = stored_q == CW'(MAX_POINTS);

  assign rx   = $signed(raw_rd_q[EW-1:VAL_W]);
  assign ry   = $signed(raw_rd_q[VAL_W-1:0]);
  assign ex   = $signed(mrg_rd_q[EW-1:VAL_W]);
  assign ey   = $signed(mrg_rd_q[VAL_W-1:0]);
  assign j_m1 = j_q - 1'b1;
  assign j_m2 = j_q - CW'(2);
  assign i_m1 = i_q - 1'b1;
  assign i_p1 = i_q + 1'b1;
  assign shift = rx > key_x_q;

  assign sum_mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign mean    = sum_q[SW-1] ? -$signed(div_q[VAL_W-1:0]) : $signed(div_q[VAL_W-1:0]);

  assign last_k   = distinct_q - 1'b1;
  assign last     = k_q == last_k;
  assign hit      = (ex >= qx_q) || last;
  assign base_cur = last && (qx_q >= ex);
  assign bx       = base_cur ? ex : prev_x_q;
  assign by       = base_cur ? ey : prev_y_q;
  assign dy       = (VAL_W+1)'(ey) - (VAL_W+1)'(prev_y_q);
  assign span     = (VAL_W+1)'(ex) - (VAL_W+1)'(prev_x_q);
  assign dq       = (VAL_W+1)'(qx_q) - (VAL_W+1)'(bx);
  assign mdy      = dy[VAL_W] ? $unsigned(-dy) : $unsigned(dy);
  assign mdq      = dq[VAL_W] ? $unsigned(-dq) : $unsigned(dq);

  assign qc = (div_q > DIVD_W'(64'h2_0000_0000)) ? (VAL_W+2)'(34'h2_0000_0000)
                                                  : div_q[VAL_W+1:0];
  assign r  = neg_q ? ((VAL_W+4)'(base_q) - $signed({2'b00, qc}))
                    : ((VAL_W+4)'(base_q) + $signed({2'b00, qc}));

  always_comb begin
    raw_we    = 1'b0;
    raw_waddr = stored_q[AW-1:0];
    raw_wdata = {sample_x_i, sample_y_i};
    case (state_q)
      S_IDLE: raw_we = accept && (cmd_e'(command_i) == CMD_ADD) && !full;
      S_SORT_CMP: begin
        raw_we    = shift;
        raw_waddr = j_q[AW-1:0];
        raw_wdata = raw_rd_q;
      end
      S_SORT_PUT: begin
        raw_we    = 1'b1;
        raw_waddr = j_q[AW-1:0];
        raw_wdata = {key_x_q, key_y_q};
      end
      default: raw_we = 1'b0;
    endcase
  end

  always_comb begin
    case (state_q)
      S_SORT_RD:  raw_raddr = i_q[AW-1:0];
      S_SORT_KEY: raw_raddr = i_m1[AW-1:0];
      S_SORT_CMP: raw_raddr = j_m2[AW-1:0];
      default:    raw_raddr = mi_q[AW-1:0];
    endcase
  end

  assign mrg_we    = (state_q == S_MRG_DIV) && div_stat.done;
  assign mrg_wdata = {cur_x_q, mean};

  always_ff @(posedge clk_i) begin
    if (raw_we) raw_mem[raw_waddr] <= raw_wdata;
    raw_rd_q <= raw_mem[raw_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mrg_we) mrg_mem[m_q[AW-1:0]] <= mrg_wdata;
    mrg_rd_q <= mrg_mem[k_q[AW-1:0]];
  end

  assign div_start = ((state_q == S_MRG_RD) && (mi_q == stored_q) && (cnt_q != '0)) ||
                     ((state_q == S_MRG_CHK) && (cnt_q != '0) && (rx != cur_x_q)) ||
                     (state_q == S_EV_DST);
  assign div_a = (state_q == S_EV_DST) ? prod_q : DIVD_W'(sum_mag);
  assign div_b = (state_q == S_EV_DST) ? span_q : DIVS_W'(cnt_q);

  pwlc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .quotient_o (div_q),
    .stat_o     (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      stored_q      <= '0;
      distinct_q    <= '0;
      ready_q       <= 1'b0;
      i_q           <= '0;
      j_q           <= '0;
      mi_q          <= '0;
      m_q           <= '0;
      cnt_q         <= '0;
      k_q           <= '0;
      key_x_q       <= '0;
      key_y_q       <= '0;
      cur_x_q       <= '0;
      qx_q          <= '0;
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      base_q        <= '0;
      sum_q         <= '0;
      mdy_q         <= '0;
      mdq_q         <= '0;
      span_q        <= '0;
      neg_q         <= 1'b0;
      prod_q        <= '0;
      res_value_q   <= '0;
      res_status_q  <= ST_OK;
      res_sat_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      curve_value_o <= '0;
      status_o      <= ST_OK;
      saturated_o   <= 1'b0;
      point_count_o <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_RESP)) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_value_q <= '0;
            res_sat_q   <= 1'b0;
            case (cmd_e'(command_i))
              CMD_CLEAR: begin
                stored_q     <= '0;
                distinct_q   <= '0;
                ready_q      <= 1'b0;
                res_status_q <= ST_OK;
                state_q      <= S_RESP;
              end
              CMD_ADD: begin
                if (full) begin
                  res_status_q <= ST_FULL;
                end else begin
                  res_status_q <= ST_OK;
                  stored_q     <= stored_q + 1'b1;
                  ready_q      <= 1'b0;
                end
                state_q <= S_RESP;
              end
              CMD_BUILD: begin
                mi_q  <= '0;
                m_q   <= '0;
                cnt_q <= '0;
                sum_q <= '0;
                i_q   <= CW'(1);
                state_q <= (stored_q > CW'(1)) ? S_SORT_RD : S_MRG_RD;
              end
              default: begin
                if (!ready_q) begin
                  res_status_q <= ST_INVALID;
                  state_q      <= S_RESP;
                end else begin
                  res_status_q <= ST_OK;
                  k_q          <= '0;
                  qx_q         <= query_x_i;
                  state_q      <= S_EV_RD;
                end
              end
            endcase
          end
        end
        S_SORT_RD: state_q <= S_SORT_KEY;
        S_SORT_KEY: begin
          key_x_q <= rx;
          key_y_q <= ry;
          j_q     <= i_q;
          state_q <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          if (shift) begin
            j_q <= j_m1;
            if (j_q == CW'(1)) state_q <= S_SORT_PUT;
          end else begin
            state_q <= S_SORT_PUT;
          end
        end
        S_SORT_PUT: begin
          i_q     <= i_p1;
          state_q <= (i_p1 < stored_q) ? S_SORT_RD : S_MRG_RD;
        end
        S_MRG_RD: begin
          if (mi_q == stored_q) begin
            if (cnt_q != '0) begin
              state_q <= S_MRG_DIV;
            end else begin
              distinct_q   <= m_q;
              ready_q      <= m_q >= CW'(2);
              res_status_q <= (m_q >= CW'(2)) ? ST_OK : ST_INVALID;
              state_q      <= S_RESP;
            end
          end else begin
            state_q <= S_MRG_CHK;
          end
        end
        S_MRG_CHK: begin
          if ((cnt_q != '0) && (rx != cur_x_q)) begin
            state_q <= S_MRG_DIV;
          end else begin
            cur_x_q <= rx;
            sum_q   <= sum_q + SW'(ry);
            cnt_q   <= cnt_q + 1'b1;
            mi_q    <= mi_q + 1'b1;
            state_q <= S_MRG_RD;
          end
        end
        S_MRG_DIV: begin
          if (div_stat.done) begin
            m_q     <= m_q + 1'b1;
            cnt_q   <= '0;
            sum_q   <= '0;
            state_q <= S_MRG_RD;
          end
        end
        S_EV_RD: state_q <= S_EV_CHK;
        S_EV_CHK: begin
          if (k_q == '0) begin
            prev_x_q <= ex;
            prev_y_q <= ey;
            k_q      <= CW'(1);
            state_q  <= S_EV_RD;
          end else if (hit) begin
            mdy_q   <= mdy[VAL_W-1:0];
            mdq_q   <= mdq[VAL_W-1:0];
            span_q  <= span[VAL_W-1:0];
            base_q  <= by;
            neg_q   <= dy[VAL_W] ^ dq[VAL_W];
            state_q <= S_EV_MUL;
          end else begin
            prev_x_q <= ex;
            prev_y_q <= ey;
            k_q      <= k_q + 1'b1;
            state_q  <= S_EV_RD;
          end
        end
        S_EV_MUL: begin
          prod_q  <= mdy_q * mdq_q;
          state_q <= S_EV_DST;
        end
        S_EV_DST: state_q <= S_EV_DIV;
        S_EV_DIV: begin
          if (div_stat.done) begin
            if (r > (VAL_W+4)'(36'sh0_7FFF_FFFF)) begin
              res_value_q <= 32'sh7FFF_FFFF;
              res_sat_q   <= 1'b1;
            end else if (r < (VAL_W+4)'(36'shF_8000_0000)) begin
              res_value_q <= 32'sh8000_0000;
              res_sat_q   <= 1'b1;
            end else begin
              res_value_q <= r[VAL_W-1:0];
            end
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q   <= 1'b1;
            curve_value_o <= res_value_q;
            status_o      <= res_status_q;
            saturated_o   <= res_sat_q;
            point_count_o <= ready_q ? PCNT_W'(distinct_q) : PCNT_W'(stored_q);
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/pwlc_checker.sv
// Port-level checker for the curve evaluator, bound to the top level.
`include "assert_macros.svh"

module pwlc_checker
  import pwlc_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [VAL_W-1:0] curve_value_o,
  input logic [1:0]              status_o,
  input logic                    saturated_o
);

  `PWLC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `PWLC_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `PWLC_ASSERT_NOW(a_err_zero, clk_i, rst_ni, out_valid_o && (status_o != ST_OK),
                   (curve_value_o == '0) && !saturated_o)
  `PWLC_ASSERT_NOW(a_sat_rail, clk_i, rst_ni, out_valid_o && saturated_o,
                   (curve_value_o == 32'sh7FFF_FFFF) || (curve_value_o == 32'sh8000_0000))

endmodule

bind piecewise_linear_curve_eval pwlc_checker u_pwlc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .curve_value_o (curve_value_o),
  .status_o      (status_o),
  .saturated_o   (saturated_o)
);
